### rtl/windowed_peak_history_assert.svh
// Assertion macros shared by the windowed peak history RTL.
`ifndef WINDOWED_PEAK_HISTORY_ASSERT_SVH
`define WINDOWED_PEAK_HISTORY_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define WPH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define WPH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wph_pkg.sv
// Package: sizes, microcode format, control program and ring helpers.
package wph_pkg;

    localparam int CHANNELS   = 4;
    localparam int WINDOW_MAX = 512;

    localparam int CHANNEL_W = 2;
    localparam int SAMPLE_W  = 32;
    localparam int WLEN_W    = 10;
    localparam int SLOT_W    = $clog2(WINDOW_MAX);
    localparam int FILL_W    = $clog2(WINDOW_MAX + 1);
    localparam int DEPTH     = CHANNELS * WINDOW_MAX;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int STEP_W    = 3;

    localparam logic [WLEN_W-1:0]   WLEN_RESET = WLEN_W'(512);
    localparam logic [SAMPLE_W-1:0] PEAK_RESET = SAMPLE_W'(1);

    typedef logic [STEP_W-1:0]   step_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [FILL_W-1:0]   fill_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

    localparam step_t STEP_IDLE    = 3'd0;
    localparam step_t STEP_CHECK   = 3'd1;
    localparam step_t STEP_HIT     = 3'd2;
    localparam step_t STEP_SCAN    = 3'd3;
    localparam step_t STEP_ADVANCE = 3'd4;
    localparam step_t STEP_APPEND  = 3'd5;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN,
        COND_EVICT,
        COND_HIT,
        COND_SCAN_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t t_true;
        step_t t_false;
        logic  take;
        logic  rd_head;
        logic  scan_init;
        logic  scan;
        logic  advance;
        logic  append;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
    } wph_ctl_t;

    typedef struct packed {
        logic in_valid;
        logic evict;
        logic hit;
        logic scan_done;
        logic out_free;
    } wph_stat_t;

    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t w;
        w = '{cond: COND_ALWAYS, t_true: STEP_IDLE, t_false: STEP_IDLE, default: 1'b0};
        case (pc)
            STEP_IDLE: begin
                w.cond = COND_IN;    w.t_true = STEP_CHECK;  w.t_false = STEP_IDLE;
                w.take = 1'b1;
            end
            STEP_CHECK: begin
                w.cond = COND_EVICT; w.t_true = STEP_HIT;    w.t_false = STEP_APPEND;
                w.rd_head = 1'b1;
            end
            STEP_HIT: begin
                w.cond = COND_HIT;   w.t_true = STEP_SCAN;   w.t_false = STEP_ADVANCE;
                w.scan_init = 1'b1;
            end
            STEP_SCAN: begin
                w.cond = COND_SCAN_DONE; w.t_true = STEP_ADVANCE; w.t_false = STEP_SCAN;
                w.scan = 1'b1;
            end
            STEP_ADVANCE: begin
                w.cond = COND_ALWAYS; w.t_true = STEP_APPEND; w.t_false = STEP_APPEND;
                w.advance = 1'b1;
            end
            STEP_APPEND: begin
                w.cond = COND_OUT_FREE; w.t_true = STEP_IDLE; w.t_false = STEP_APPEND;
                w.append = 1'b1;
            end
            default: begin
                w.cond = COND_ALWAYS; w.t_true = STEP_IDLE; w.t_false = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic slot_t slot_after(slot_t base, fill_t offset);
        logic [FILL_W:0] s;
        s = (FILL_W + 1)'(base) + (FILL_W + 1)'(offset);
        if (s >= (FILL_W + 1)'(WINDOW_MAX)) begin
            s = s - (FILL_W + 1)'(WINDOW_MAX);
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic addr_t mem_addr(logic [CHANNEL_W-1:0] ch, slot_t slot);
        return ADDR_W'(ch) * ADDR_W'(WINDOW_MAX) + ADDR_W'(slot);
    endfunction

endpackage

### rtl/wph_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module wph_seq
    import wph_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  wph_stat_t stat,
    output wph_ctl_t  ctl
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t uc;
    logic   go;

    always_comb begin
        uc = ucode_rom(pc_reg);
        case (uc.cond)
            COND_ALWAYS:    go = 1'b1;
            COND_IN:        go = stat.in_valid;
            COND_EVICT:     go = stat.evict;
            COND_HIT:       go = stat.hit;
            COND_SCAN_DONE: go = stat.scan_done;
            COND_OUT_FREE:  go = stat.out_free;
            default:        go = 1'b1;
        endcase
        pc_next = go ? uc.t_true : uc.t_false;
        ctl.uc  = uc;
        ctl.go  = go;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/windowed_peak_history.sv
// Top level: windowed peak history with per-channel rings and a shared peak.
// A taken request passes the check and append steps; an eviction adds the hit test and
// the ring advance, plus a rescan of the ring when the evicted entry held the peak.
// The rescan loop, one history memory read per cycle, sets the worst case; a held result
// stalls input, and no new request is taken until the last one has been appended.
// Reset: peak 1, window length 512, all rings empty; no memory clearing pass.
`include "windowed_peak_history_assert.svh"
module windowed_peak_history
    import wph_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [WLEN_W-1:0]    cfg_wr_data,   // window_length
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,       // [31:0] sample
    input  logic [CHANNEL_W-1:0] s_tuser,       // [1:0] channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata        // [31:0] peak
);

    wph_ctl_t  ctl;
    wph_stat_t stat;

    logic [WLEN_W-1:0]    wlen_reg;
    slot_t                head_reg [CHANNELS];
    fill_t                fill_reg [CHANNELS];
    sample_t              peak_reg;
    sample_t              peak_next;

    logic [CHANNEL_W-1:0] ch_reg;
    sample_t              smp_reg;
    slot_t                head_cur_reg;
    fill_t                fill_cur_reg;
    fill_t                idx_reg;
    sample_t              best_reg;
    logic                 pend_reg;

    sample_t              hist_mem [DEPTH];
    sample_t              rd_data_reg;
    addr_t                rd_addr;
    addr_t                wr_addr;
    logic                 wr_en;

    logic                 m_tvalid_reg;
    sample_t              m_tdata_reg;

    fill_t                eff_win;
    logic                 ch_ok;
    logic                 issue;
    logic                 take_fire;
    logic                 append_fire;
    logic                 scan_end;

    wph_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    always_comb begin
        if (wlen_reg == '0) begin
            eff_win = FILL_W'(1);
        end else if (32'(wlen_reg) > WINDOW_MAX) begin
            eff_win = FILL_W'(WINDOW_MAX);
        end else begin
            eff_win = FILL_W'(wlen_reg);
        end
    end

    assign ch_ok       = 32'(ch_reg) < CHANNELS;
    assign issue       = idx_reg < fill_cur_reg;
    assign take_fire   = ctl.uc.take & ctl.go;
    assign append_fire = ctl.uc.append & ctl.go;
    assign scan_end    = ctl.uc.scan & stat.scan_done;

    assign stat.in_valid  = s_tvalid;
    assign stat.evict     = ch_ok && (fill_cur_reg >= eff_win) && (fill_cur_reg != '0);
    assign stat.hit       = rd_data_reg >= peak_reg;
    assign stat.scan_done = !issue && !pend_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = ctl.uc.take;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_addr = mem_addr(ch_reg, slot_after(head_cur_reg,
                                                 ctl.uc.rd_head ? '0 : idx_reg));
    assign wr_addr = mem_addr(ch_reg, slot_after(head_cur_reg, fill_cur_reg));
    assign wr_en   = append_fire && ch_ok;

    always_comb begin
        peak_next = peak_reg;
        if (scan_end) begin
            peak_next = best_reg;
        end
        if (append_fire && ch_ok && (peak_reg <= smp_reg)) begin
            peak_next = smp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[rd_addr];
        if (wr_en) begin
            hist_mem[wr_addr] <= smp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_fire) begin
            ch_reg       <= s_tuser;
            smp_reg      <= s_tdata;
            head_cur_reg <= head_reg[s_tuser];
            fill_cur_reg <= fill_reg[s_tuser];
        end
        if (ctl.uc.scan_init) begin
            idx_reg  <= FILL_W'(1);
            best_reg <= '0;
        end
        if (ctl.uc.scan) begin
            if (issue) begin
                idx_reg <= idx_reg + FILL_W'(1);
            end
            if (pend_reg && (rd_data_reg > best_reg)) begin
                best_reg <= rd_data_reg;
            end
        end
        if (ctl.uc.advance) begin
            head_cur_reg <= slot_after(head_cur_reg, FILL_W'(1));
            fill_cur_reg <= fill_cur_reg - FILL_W'(1);
        end
        if (append_fire) begin
            m_tdata_reg <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg     <= WLEN_RESET;
            peak_reg     <= PEAK_RESET;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            peak_reg <= peak_next;
            if (ctl.uc.scan_init) begin
                pend_reg <= 1'b0;
            end else if (ctl.uc.scan) begin
                pend_reg <= issue;
            end
            if (wr_en) begin
                head_reg[ch_reg] <= head_cur_reg;
                fill_reg[ch_reg] <= fill_cur_reg + FILL_W'(1);
            end
            if (append_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `WPH_ASSERT_NXT(a_result_after_append, append_fire, m_tvalid_reg,
                    "result not presented after append")
    `WPH_ASSERT_NXT(a_peak_covers_sample, append_fire && ch_ok,
                    peak_reg >= $past(smp_reg), "peak below appended sample")
    `WPH_ASSERT_IMP(a_scan_in_bounds, ctl.uc.scan, idx_reg <= fill_cur_reg,
                    "rescan index beyond fill")
    `WPH_ASSERT_IMP(a_append_fill_room, wr_en, fill_cur_reg < FILL_W'(WINDOW_MAX),
                    "append into full ring")

endmodule
